[hw/rtl/nfsa_pkg.sv]
// Shared types, codes and sizes for the next-fit slot allocator.
// No dependencies; compiled first.
package nfsa_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = 4;   // width of a slot index
    localparam int CNT_W = 5;   // width of the slot count register
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(SLOTS);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } nfsa_state_t;

    typedef struct packed {
        logic load_in;   // capture the request payload
        logic exec;      // run the search or free and load the result
    } nfsa_cmd_t;

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [IDX_W-1:0] first_set(input logic [SLOTS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/nfsa_if.sv]
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on nfsa_pkg for the field widths.
interface nfsa_req_if;
    import nfsa_pkg::*;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [IDX_W-1:0] slot_to_free;

    modport source (output valid, output mode, output slot_to_free, input ready);
    modport sink   (input valid, input mode, input slot_to_free, output ready);
endinterface

interface nfsa_rsp_if;
    import nfsa_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] granted_slot;
    logic [1:0]       status;

    modport source (output valid, output granted_slot, output status, input ready);
    modport sink   (input valid, input granted_slot, input status, output ready);
endinterface

[hw/rtl/next_fit_slot_allocator_core.sv]
// Next-fit slot allocator over a pool of up to 16 buffer slots.
// Depends on nfsa_pkg, nfsa_if, nfsa_ctrl and nfsa_dp.
//
// Usage:
//   req  : valid/ready channel carrying mode (0 allocate, 1 free) and
//          slot_to_free. A transfer takes place when valid and ready are high.
//   rsp  : valid/ready channel carrying granted_slot and status
//          (0 ok, 1 pool full, 2 free index out of range). One response per
//          request, in request order.
//   cfg_we / cfg_wdata : writes the managed slot count (reset 16); write
//          only while no request is outstanding.
// Timing: a request is captured on its transfer, the search and bitmap
//   update run in S_EXEC, and the response is presented in S_RESP on the
//   next cycle. The whole bitmap is searched at once; the block does not
//   take a new request until the pending response has transferred.
// Reset: clears the bitmap (all slots free), the search pointer and the
//   state machine; the slot count returns to 16. No clearing pass is needed.
// Stall: while rsp is not taken the response holds and req stays low ready;
//   the next request is accepted in the cycle the pending response transfers.
module next_fit_slot_allocator_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    nfsa_req_if.sink                   req,
    nfsa_rsp_if.source                 rsp,
    input  logic                       cfg_we,
    input  logic [nfsa_pkg::CNT_W-1:0] cfg_wdata
);
    import nfsa_pkg::*;

    nfsa_cmd_t cmd;

    nfsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    nfsa_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .mode         (req.mode),
        .slot_to_free (req.slot_to_free),
        .granted_slot (rsp.granted_slot),
        .status       (rsp.status)
    );

endmodule

[hw/rtl/nfsa_ctrl.sv]
// Controller state machine for the slot allocator: sequences capture,
// execute and response. Depends on nfsa_pkg.
module nfsa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output nfsa_pkg::nfsa_cmd_t cmd
);
    import nfsa_pkg::*;

    nfsa_state_t state_reg;
    nfsa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_ready   = 1'b0;
        rsp_valid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                rsp_valid = 1'b1;
                // next request may be taken in the same cycle the response leaves
                req_ready = rsp_ready;
                if (rsp_ready)
                begin
                    if (req_valid)
                    begin
                        cmd.load_in = 1'b1;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/nfsa_dp.sv]
// Datapath for the slot allocator: used bitmap, search pointer, slot count
// register, next-fit search and result registers. Depends on nfsa_pkg.
module nfsa_dp
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  nfsa_pkg::nfsa_cmd_t        cmd,
    input  logic                       cfg_we,
    input  logic [nfsa_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                       mode,
    input  logic [nfsa_pkg::IDX_W-1:0] slot_to_free,
    output logic [nfsa_pkg::IDX_W-1:0] granted_slot,
    output logic [1:0]                 status
);
    import nfsa_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [SLOTS-1:0] used_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic             mode_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] granted_reg;
    logic [1:0]       status_reg;

    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] start;
    logic [SLOTS-1:0] free_vec;
    logic [SLOTS-1:0] upper_vec;
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] pos_inc;
    logic [IDX_W-1:0] ptr_next;
    logic             free_ok;

    always_comb
    begin
        // clamp count to 1..SLOTS
        if (count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (count_reg > CNT_W'(SLOTS))
        begin
            n_eff = CNT_W'(SLOTS);
        end
        else
        begin
            n_eff = count_reg;
        end

        start = ({1'b0, ptr_reg} < n_eff) ? ptr_reg : '0;

        for (int i = 0; i < SLOTS; i++)
        begin
            free_vec[i]  = !used_reg[i] && (CNT_W'(i) < n_eff);
            upper_vec[i] = free_vec[i] && (IDX_W'(i) >= start);
        end

        found    = |free_vec;
        // free slot at or past the pointer first, else wrap to the lowest
        pos      = (|upper_vec) ? first_set(upper_vec) : first_set(free_vec);
        pos_inc  = {1'b0, pos} + CNT_W'(1);
        ptr_next = (pos_inc >= n_eff) ? '0 : pos_inc[IDX_W-1:0];
        free_ok  = {1'b0, slot_reg} < n_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_RESET;
            used_reg  <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    if (found)
                    begin
                        used_reg[pos] <= 1'b1;
                        ptr_reg       <= ptr_next;
                    end
                end
                else if (free_ok)
                begin
                    used_reg[slot_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode;
            slot_reg <= slot_to_free;
        end
        if (cmd.exec)
        begin
            if (mode_reg == MODE_ALLOC)
            begin
                granted_reg <= found ? pos : '0;
                status_reg  <= found ? ST_OK : ST_FULL;
            end
            else
            begin
                granted_reg <= '0;
                status_reg  <= free_ok ? ST_OK : ST_RANGE;
            end
        end
    end

    assign granted_slot = granted_reg;
    assign status       = status_reg;

endmodule
